/* hw/rtl/dctc_pkg.sv */
`timescale 1ns / 1ps
package dctc_pkg;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_MIN  = 2'd1;
  localparam logic [1:0] CMD_HOUR = 2'd2;

  localparam logic [15:0] DRIFT_STEP_RESET = 16'd1229;
  localparam logic [6:0]  SEC_PER_MIN      = 7'd60;
  localparam logic [5:0]  MIN_LAST         = 6'd59;
  localparam logic [4:0]  HOUR_LAST        = 5'd23;
  localparam logic [3:0]  LEVEL_COUNT      = 4'd5;
  localparam logic [2:0]  LEVEL_RESET      = 3'd1;
  localparam logic [7:0]  PWM_RESET        = 8'd248;

  typedef struct packed {
    logic [5:0] minute_lights;
    logic [4:0] hour_lights;
    logic [7:0] pwm_compare;
    logic       sleep_deep;
    logic [5:0] second_count;
  } dctc_result_t;

  function automatic logic [7:0] level_pwm(input logic [2:0] lv);
    logic [7:0] v;
    case (lv)
      3'd0:    v = 8'd255;
      3'd1:    v = 8'd254;
      3'd2:    v = 8'd248;
      3'd3:    v = 8'd156;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/dctc_if.sv */
`timescale 1ns / 1ps
interface dctc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       brightness_button;

  modport source (output valid, output command, output brightness_button, input ready);
  modport sink   (input valid, input command, input brightness_button, output ready);
endinterface

interface dctc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] minute_lights;
  logic [4:0] hour_lights;
  logic [7:0] pwm_compare;
  logic       sleep_deep;
  logic [5:0] second_count;

  modport source (output valid, output minute_lights, output hour_lights,
                  output pwm_compare, output sleep_deep, output second_count,
                  input ready);
  modport sink   (input valid, input minute_lights, input hour_lights,
                  input pwm_compare, input sleep_deep, input second_count,
                  output ready);
endinterface

/* hw/rtl/drift_corrected_time_of_day_clock_unit.sv */
`timescale 1ns / 1ps
// 24-hour time-of-day clock with a Q0.16 drift accumulator and a five-level
// brightness step. One command is taken per clock cycle while ready is high; its
// result is registered into the result register, or into the skid register when
// the sink stalls. The time state updates in the cycle of the transfer through
// a single increment/carry path, and a two-entry output buffer (result register
// plus skid register) keeps the input ready while one result waits, so a stalled
// sink costs no throughput until both entries are full. drift_step is written
// through cfg_we/cfg_wdata and takes effect on the next tick.
module drift_corrected_time_of_day_clock_unit (
  input  logic        clk,
  input  logic        rst_n,
  dctc_in_if.sink     in_ch,
  dctc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import dctc_pkg::*;

  logic [15:0] drift_step_r;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [2:0]  bright_r, bright_nxt;
  logic [7:0]  pwm_r, pwm_nxt;
  logic        deep_r, deep_nxt;

  dctc_result_t res;
  dctc_result_t out_r, skid_r;
  logic         out_valid_r, skid_valid_r;
  logic         accept, load;

  logic [16:0] sum;
  logic [6:0]  s;
  logic [3:0]  lv;
  logic        adv_min, adv_hour, show;

  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign load        = !out_valid_r || out_ch.ready;

  always_comb begin
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    frac_nxt   = frac_r;
    bright_nxt = bright_r;
    pwm_nxt    = pwm_r;
    deep_nxt   = deep_r;
    adv_min    = 1'b0;
    adv_hour   = 1'b0;
    show       = !deep_r;
    sum        = {1'b0, frac_r} + {1'b0, drift_step_r};
    s          = {1'b0, sec_r} + 7'd1 + {6'd0, sum[16]};
    lv         = {1'b0, bright_r} + 4'd1;
    if (lv >= LEVEL_COUNT) begin
      lv = 4'd0;
    end
    case (in_ch.command)
      CMD_TICK: begin
        frac_nxt = sum[15:0];
        if (s >= SEC_PER_MIN) begin
          s       = s - SEC_PER_MIN;
          adv_min = 1'b1;
        end
        sec_nxt = s[5:0];
        if (in_ch.brightness_button) begin
          bright_nxt = lv[2:0];
          pwm_nxt    = level_pwm(lv[2:0]);
        end
        deep_nxt = (bright_nxt == 3'd0);
        show     = !deep_nxt;
      end
      CMD_MIN: begin
        adv_min = 1'b1;
        show    = 1'b1;
      end
      CMD_HOUR: begin
        adv_hour = 1'b1;
        show     = 1'b1;
      end
      default: begin
        show = !deep_r;
      end
    endcase
    if (adv_min) begin
      if (min_r >= MIN_LAST) begin
        min_nxt  = 6'd0;
        adv_hour = 1'b1;
      end else begin
        min_nxt = min_r + 6'd1;
      end
    end
    if (adv_hour) begin
      hour_nxt = (hour_r >= HOUR_LAST) ? 5'd0 : hour_r + 5'd1;
    end
    res.minute_lights = show ? min_nxt : 6'd0;
    res.hour_lights   = show ? hour_nxt : 5'd0;
    res.pwm_compare   = pwm_nxt;
    res.sleep_deep    = deep_nxt;
    res.second_count  = sec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drift_step_r <= DRIFT_STEP_RESET;
      sec_r        <= 6'd0;
      min_r        <= 6'd0;
      hour_r       <= 5'd0;
      frac_r       <= 16'd0;
      bright_r     <= LEVEL_RESET;
      pwm_r        <= PWM_RESET;
      deep_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        drift_step_r <= cfg_wdata;
      end
      if (accept) begin
        sec_r    <= sec_nxt;
        min_r    <= min_nxt;
        hour_r   <= hour_nxt;
        frac_r   <= frac_nxt;
        bright_r <= bright_nxt;
        pwm_r    <= pwm_nxt;
        deep_r   <= deep_nxt;
      end
    end
  end

  // output buffer: skid entry fills only when the result register is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.minute_lights = out_r.minute_lights;
  assign out_ch.hour_lights   = out_r.hour_lights;
  assign out_ch.pwm_compare   = out_r.pwm_compare;
  assign out_ch.sleep_deep    = out_r.sleep_deep;
  assign out_ch.second_count  = out_r.second_count;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import dctc_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_ITEMS = 205;
  localparam int         PHASES      = 7;
  localparam int         SHOW_LIMIT  = 10;

  // Tracks the clock state and the results it must produce.
  class clock_scoreboard;
    logic [15:0]  drift_step;
    logic [15:0]  drift_frac;
    logic [5:0]   sec_count;
    logic [5:0]   min_count;
    logic [4:0]   hour_count;
    logic [2:0]   level;
    logic [7:0]   pwm;
    logic         deep;
    logic [7:0]   pwm_levels [5];
    dctc_result_t expected_q [$];
    int           mismatches;

    function new();
      pwm_levels = '{8'd255, 8'd254, 8'd248, 8'd156, 8'd0};
      mismatches = 0;
      drift_step = DRIFT_STEP_RESET;
      drift_frac = '0;
      sec_count  = '0;
      min_count  = '0;
      hour_count = '0;
      level      = LEVEL_RESET;
      pwm        = PWM_RESET;
      deep       = 1'b0;
    endfunction

    function void bump_hour();
      if (hour_count >= HOUR_LAST) hour_count = '0;
      else hour_count = hour_count + 5'd1;
    endfunction

    function void bump_minute();
      if (min_count >= MIN_LAST) begin
        min_count = '0;
        bump_hour();
      end else begin
        min_count = min_count + 6'd1;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function string describe(dctc_result_t r);
      return $sformatf("min %0d hr %0d pwm %0d deep %0d sec %0d", r.minute_lights,
                       r.hour_lights, r.pwm_compare, r.sleep_deep, r.second_count);
    endfunction

    function void note_input(logic [1:0] cmd, logic btn);
      logic [16:0]  sum;
      logic [6:0]   secs;
      logic [3:0]   lv;
      logic         show;
      dctc_result_t r;
      show = 1'b1;
      case (cmd)
        CMD_TICK: begin
          sum = {1'b0, drift_frac} + {1'b0, drift_step};
          secs = {1'b0, sec_count} + 7'd1 + {6'd0, sum[16]};
          drift_frac = sum[15:0];
          if (secs >= SEC_PER_MIN) begin
            secs = secs - SEC_PER_MIN;
            bump_minute();
          end
          sec_count = secs[5:0];
          if (btn) begin
            lv = {1'b0, level} + 4'd1;
            if (lv >= LEVEL_COUNT) lv = '0;
            level = lv[2:0];
            pwm = pwm_levels[lv[2:0]];
          end
          deep = (level == 3'd0);
          show = !deep;
        end
        CMD_MIN: bump_minute();
        CMD_HOUR: bump_hour();
        default: show = !deep;
      endcase
      r.minute_lights = show ? min_count : 6'd0;
      r.hour_lights   = show ? hour_count : 5'd0;
      r.pwm_compare   = pwm;
      r.sleep_deep    = deep;
      r.second_count  = sec_count;
      expected_q.push_back(r);
    endfunction

    function void check_result(dctc_result_t got);
      dctc_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: transfer with nothing expected: %s", $time, describe(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.minute_lights !== want.minute_lights || got.hour_lights !== want.hour_lights ||
          got.pwm_compare !== want.pwm_compare || got.sleep_deep !== want.sleep_deep ||
          got.second_count !== want.second_count) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: expected %s, got %s", $time, describe(want), describe(got));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          cycles;
  bit          calm;
  bit          long_hold;
  int          src_odds;
  int          sink_odds;

  clock_scoreboard sb = new();

  dctc_in_if  in_ch();
  dctc_out_if out_ch();

  drift_corrected_time_of_day_clock_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    dctc_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.command, in_ch.brightness_button);
      if (out_ch.valid && out_ch.ready) begin
        got.minute_lights = out_ch.minute_lights;
        got.hour_lights   = out_ch.hour_lights;
        got.pwm_compare   = out_ch.pwm_compare;
        got.sleep_deep    = out_ch.sleep_deep;
        got.second_count  = out_ch.second_count;
        sb.check_result(got);
      end
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (80) @(negedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(1, sink_odds) == 1) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic btn);
    @(negedge clk);
    in_ch.valid             <= 1'b1;
    in_ch.command           <= cmd;
    in_ch.brightness_button <= btn;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic sender_gap(input int n);
    @(negedge clk);
    in_ch.valid             <= 1'b0;
    in_ch.command           <= 2'($urandom);
    in_ch.brightness_button <= 1'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    sender_gap(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_drift(input logic [15:0] v);
    drain();
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.drift_step = v;
  endtask

  task automatic random_item();
    int         r;
    logic [1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 55) cmd = CMD_TICK;
    else if (r < 75) cmd = CMD_MIN;
    else if (r < 93) cmd = CMD_HOUR;
    else cmd = CMD_UNUSED;
    if (!calm && $urandom_range(1, src_odds) == 1) sender_gap($urandom_range(1, 9));
    send_item(cmd, 1'($urandom));
  endtask

  initial begin
    logic [15:0] phase_drift [PHASES];
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = '0;
    in_ch.valid             = 1'b0;
    in_ch.command           = CMD_TICK;
    in_ch.brightness_button = 1'b0;
    cycles                  = 0;
    calm                    = 1'b0;
    long_hold               = 1'b0;
    src_odds                = 6;
    sink_odds               = 6;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // walk the brightness table into deep sleep and back out
    send_item(CMD_TICK, 1'b0);
    repeat (4) send_item(CMD_TICK, 1'b1);
    send_item(CMD_UNUSED, 1'b0);
    send_item(CMD_MIN, 1'b1);
    send_item(CMD_HOUR, 1'b0);
    send_item(CMD_UNUSED, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_UNUSED, 1'b0);

    // largest drift: carry on almost every tick
    write_drift(16'hFFFF);
    repeat (6) send_item(CMD_TICK, 1'b0);

    // no drift: plain one-second steps
    write_drift(16'h0000);
    repeat (3) send_item(CMD_TICK, 1'b0);
    send_item(CMD_HOUR, 1'b1);
    send_item(CMD_MIN, 1'b0);

    phase_drift = '{16'($urandom), 16'hFFFF, 16'h0000, 16'($urandom),
                    DRIFT_STEP_RESET, 16'($urandom), 16'($urandom)};
    for (int p = 0; p < PHASES; p++) begin
      write_drift(phase_drift[p]);
      src_odds  = $urandom_range(2, 20);
      sink_odds = $urandom_range(2, 20);
      calm      = (p == PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 40) long_hold = 1'b1;
        if (p == 3 && i == 100) drain();
        random_item();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
